@@ hdl/tmmu_pkg.sv @@
package tmmu_pkg;

	localparam int NUM_TAGS   = 4;
	localparam int MAX_PAGES  = 256;
	localparam int MAX_FRAMES = 256;

	localparam int TAG_W      = 5;
	localparam int PAGE_W     = 8;
	localparam int FRAME_W    = 8;
	localparam int PROT_W     = 2;
	localparam int BITS_W     = 2;
	localparam int STATUS_W   = 4;
	localparam int PAGES_W    = 9;
	localparam int FRAMES_W   = 9;
	localparam int LIMIT_W    = 11;
	localparam int COUNT_W    = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam int TAG_IDX_W  = $clog2(NUM_TAGS);
	localparam int MAP_AW     = TAG_IDX_W + PAGE_W;
	localparam int MAP_DEPTH  = NUM_TAGS * MAX_PAGES;
	localparam int ENTRY_W    = 1 + FRAME_W + PROT_W;
	localparam int ENT_VALID  = ENTRY_W - 1;

	localparam logic [PAGES_W-1:0]  PAGES_RESET  = 9'd256;
	localparam logic [FRAMES_W-1:0] FRAMES_RESET = 9'd256;
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 11'd1024;

	typedef enum logic [2:0] {
		CMD_MAP     = 3'd0,
		CMD_UNMAP   = 3'd1,
		CMD_GET_MAP = 3'd2,
		CMD_SET_ACC = 3'd3,
		CMD_GET_ACC = 3'd4,
		CMD_SET_TAG = 3'd5,
		CMD_GET_TAG = 3'd6,
		CMD_ACCESS  = 3'd7
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 4'd0,
		ST_PAGE  = 4'd1,
		ST_FRAME = 4'd2,
		ST_MAPS  = 4'd3,
		ST_PROT  = 4'd4,
		ST_TAG   = 4'd5,
		ST_REMAP = 4'd6,
		ST_NOMAP = 4'd7,
		ST_FAULT = 4'd8,
		ST_VIOL  = 4'd9
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAGES  = 2'd0,
		CFG_FRAMES = 2'd1,
		CFG_LIMIT  = 2'd2,
		CFG_NONE   = 2'd3
	} cfg_idx_t;

	localparam logic [PROT_W-1:0] PROT_NOACC = 2'd0;
	localparam logic [PROT_W-1:0] PROT_RO    = 2'd1;
	localparam logic [PROT_W-1:0] PROT_BAD   = 2'd2;
	localparam logic [PROT_W-1:0] PROT_RW    = 2'd3;

	localparam logic [TAG_W-1:0] TAG_NONE = 5'b11111;

	// Write request for the mapping memory.
	typedef struct packed {
		logic               en;
		logic [MAP_AW-1:0]  addr;
		logic [ENTRY_W-1:0] data;
	} map_wr_t;

	// Write request for the frame status memory, with one enable per bit.
	typedef struct packed {
		logic [BITS_W-1:0]  mask;
		logic [FRAME_W-1:0] addr;
		logic [BITS_W-1:0]  data;
	} bits_wr_t;

	// State of the clearing sweep after reset.
	typedef struct packed {
		logic              busy;
		logic [MAP_AW-1:0] addr;
	} clr_t;

	// A tag that cannot select a mapping: negative or beyond the tag count.
	function automatic logic tag_bad(input logic [TAG_W-1:0] t);
		return t[TAG_W-1] || (int'(t[TAG_W-2:0]) >= NUM_TAGS);
	endfunction

endpackage

@@ hdl/tagged_mmu_map_table.sv @@
// Tagged page-to-frame mapping table with per-frame reference and dirty bits.
// Input channel (in_valid/in_stall) carries one command transaction; each one
// produces exactly one result transaction on the output channel
// (out_valid/out_stall). A configuration write channel (cfg_valid/cfg_ready,
// always ready) sets the page count, frame count and mapping limit; writes
// to index 3 are ignored, and configuration should only change while idle.
// A command is held in the working stage while its memory reads return,
// then its result moves to the output register. One command is in flight
// at a time: a new one is taken only once the last has left the working
// stage, as the mapping memory is read, modified and written back there.
// The result sits in an output register, so a stalled receiver does not stop
// the next command from being read; a second result waits in the working
// stage until the output register drains, and only then is a third taken.
// After reset a sweep clears the 1024 mapping entries and the 256 frame
// entries, one mapping entry per cycle; in_stall is high during the sweep.
// Configuration writes are taken during the sweep too.
module tagged_mmu_map_table (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// command channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [2:0]                            command,
	input  logic signed [tmmu_pkg::TAG_W-1:0]     tag_in,
	input  logic [tmmu_pkg::PAGE_W-1:0]           page_in,
	input  logic [tmmu_pkg::FRAME_W-1:0]          frame_in,
	input  logic [tmmu_pkg::PROT_W-1:0]           protection_in,
	input  logic [tmmu_pkg::BITS_W-1:0]           access_bits_in,
	input  logic                                  is_write,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [tmmu_pkg::STATUS_W-1:0]         status,
	output logic [tmmu_pkg::FRAME_W-1:0]          frame_out,
	output logic [tmmu_pkg::PROT_W-1:0]           protection_out,
	output logic [tmmu_pkg::BITS_W-1:0]           access_bits_out,
	output logic signed [tmmu_pkg::TAG_W-1:0]     tag_out,
	// configuration channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tmmu_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tmmu_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// Configuration registers.
	logic [tmmu_pkg::PAGES_W-1:0]  pages_q;
	logic [tmmu_pkg::FRAMES_W-1:0] frames_q;
	logic [tmmu_pkg::LIMIT_W-1:0]  limit_q;

	// Architectural state kept in flip-flops.
	logic [tmmu_pkg::COUNT_W-1:0]  count_q;
	logic [tmmu_pkg::TAG_W-1:0]    cur_tag_q;

	// Working stage: the command whose memory reads are in flight.
	logic                          valid_s1;
	tmmu_pkg::cmd_t                cmd_s1;
	logic [tmmu_pkg::TAG_W-1:0]    tag_s1;
	logic [tmmu_pkg::PAGE_W-1:0]   page_s1;
	logic [tmmu_pkg::FRAME_W-1:0]  frame_s1;
	logic [tmmu_pkg::PROT_W-1:0]   prot_s1;
	logic [tmmu_pkg::BITS_W-1:0]   acc_s1;
	logic                          wr_s1;
	logic [tmmu_pkg::MAP_AW-1:0]   map_addr_s1;

	// Output register.
	logic                          out_valid_q;
	logic [tmmu_pkg::STATUS_W-1:0] status_q;
	logic [tmmu_pkg::FRAME_W-1:0]  frame_out_q;
	logic [tmmu_pkg::PROT_W-1:0]   prot_out_q;
	logic [tmmu_pkg::BITS_W-1:0]   bits_out_q;
	logic [tmmu_pkg::TAG_W-1:0]    tag_out_q;

	tmmu_pkg::clr_t                clr;
	logic                          accept;
	logic                          done;
	logic [tmmu_pkg::MAP_AW-1:0]   map_rd_addr;
	logic [tmmu_pkg::ENTRY_W-1:0]  map_rd_data;
	logic [tmmu_pkg::BITS_W-1:0]   bits_rd_data;
	tmmu_pkg::map_wr_t             map_wr_c;
	tmmu_pkg::map_wr_t             map_wr;
	tmmu_pkg::bits_wr_t            bits_wr_c;
	tmmu_pkg::bits_wr_t            bits_wr;

	// Result of the working stage.
	tmmu_pkg::status_t             st_c;
	logic [tmmu_pkg::FRAME_W-1:0]  fo_c;
	logic [tmmu_pkg::PROT_W-1:0]   po_c;
	logic [tmmu_pkg::BITS_W-1:0]   ao_c;
	logic [tmmu_pkg::TAG_W-1:0]    to_c;
	logic                          cnt_inc_c;
	logic                          cnt_dec_c;
	logic                          tag_set_c;

	logic                          page_bad_s1;
	logic                          frame_bad_s1;
	logic                          ent_valid_s1;
	logic [tmmu_pkg::FRAME_W-1:0]  ent_frame_s1;
	logic [tmmu_pkg::PROT_W-1:0]   ent_prot_s1;
	logic                          set_tag_bad_s1;

	tmmu_clear u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr)
	);

	// A command is taken only while the working stage is empty and the
	// clearing sweep has finished.
	assign in_stall = clr.busy | valid_s1;
	assign accept   = in_valid & ~in_stall;
	// The working stage retires when the output register is free or draining.
	assign done     = valid_s1 & (~out_valid_q | ~out_stall);

	// An access looks up its page under the current tag; the other commands
	// under the tag they carry.
	always_comb begin
		if (command == tmmu_pkg::CMD_ACCESS) begin
			map_rd_addr = {cur_tag_q[tmmu_pkg::TAG_IDX_W-1:0], page_in};
		end else begin
			map_rd_addr = {tag_in[tmmu_pkg::TAG_IDX_W-1:0], page_in};
		end
	end

	tmmu_map_ram u_map_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (map_rd_addr),
		.rd_data (map_rd_data),
		.wr      (map_wr)
	);

	tmmu_bits_ram u_bits_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (frame_in),
		.rd_data (bits_rd_data),
		.wr      (bits_wr)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_q  <= tmmu_pkg::PAGES_RESET;
			frames_q <= tmmu_pkg::FRAMES_RESET;
			limit_q  <= tmmu_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (tmmu_pkg::cfg_idx_t'(cfg_index))
				tmmu_pkg::CFG_PAGES: begin
					pages_q <= cfg_data[tmmu_pkg::PAGES_W-1:0];
				end
				tmmu_pkg::CFG_FRAMES: begin
					frames_q <= cfg_data[tmmu_pkg::FRAMES_W-1:0];
				end
				tmmu_pkg::CFG_LIMIT: begin
					limit_q <= cfg_data[tmmu_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Capture the command as its memory reads are issued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= tmmu_pkg::cmd_t'(command);
			tag_s1      <= tag_in;
			page_s1     <= page_in;
			frame_s1    <= frame_in;
			prot_s1     <= protection_in;
			acc_s1      <= access_bits_in;
			wr_s1       <= is_write;
			map_addr_s1 <= map_rd_addr;
		end
	end

	// Decode of the fetched entry and the range checks.
	assign page_bad_s1  = {1'b0, page_s1} >= pages_q;
	assign frame_bad_s1 = {1'b0, frame_s1} >= frames_q;
	assign ent_valid_s1 = map_rd_data[tmmu_pkg::ENT_VALID];
	assign ent_frame_s1 = map_rd_data[tmmu_pkg::ENT_VALID-1:tmmu_pkg::PROT_W];
	assign ent_prot_s1  = map_rd_data[tmmu_pkg::PROT_W-1:0];
	// Set tag accepts the no-context value as well as every real tag.
	assign set_tag_bad_s1 = tmmu_pkg::tag_bad(tag_s1) && (tag_s1 != tmmu_pkg::TAG_NONE);

	always_comb begin
		st_c           = tmmu_pkg::ST_OK;
		fo_c           = '0;
		po_c           = '0;
		ao_c           = '0;
		to_c           = '0;
		cnt_inc_c      = 1'b0;
		cnt_dec_c      = 1'b0;
		tag_set_c      = 1'b0;
		map_wr_c.en    = 1'b0;
		map_wr_c.addr  = map_addr_s1;
		map_wr_c.data  = '0;
		bits_wr_c.mask = '0;
		bits_wr_c.addr = frame_s1;
		bits_wr_c.data = acc_s1;
		case (cmd_s1)
			tmmu_pkg::CMD_MAP: begin
				if (page_bad_s1) begin
					st_c = tmmu_pkg::ST_PAGE;
				end else if (frame_bad_s1) begin
					st_c = tmmu_pkg::ST_FRAME;
				end else if (count_q >= limit_q) begin
					st_c = tmmu_pkg::ST_MAPS;
				end else if (prot_s1 == tmmu_pkg::PROT_BAD) begin
					st_c = tmmu_pkg::ST_PROT;
				end else if (tmmu_pkg::tag_bad(tag_s1)) begin
					st_c = tmmu_pkg::ST_TAG;
				end else if (ent_valid_s1) begin
					st_c = tmmu_pkg::ST_REMAP;
				end else begin
					map_wr_c.en   = 1'b1;
					map_wr_c.data = {1'b1, frame_s1, prot_s1};
					cnt_inc_c     = 1'b1;
				end
			end
			tmmu_pkg::CMD_UNMAP, tmmu_pkg::CMD_GET_MAP: begin
				if (page_bad_s1) begin
					st_c = tmmu_pkg::ST_PAGE;
				end else if (tmmu_pkg::tag_bad(tag_s1)) begin
					st_c = tmmu_pkg::ST_TAG;
				end else if (!ent_valid_s1) begin
					st_c = tmmu_pkg::ST_NOMAP;
				end else if (cmd_s1 == tmmu_pkg::CMD_UNMAP) begin
					map_wr_c.en = 1'b1;
					cnt_dec_c   = (count_q != '0);
				end else begin
					fo_c = ent_frame_s1;
					po_c = ent_prot_s1;
				end
			end
			tmmu_pkg::CMD_SET_ACC: begin
				if (frame_bad_s1) begin
					st_c = tmmu_pkg::ST_FRAME;
				end else begin
					bits_wr_c.mask = '1;
				end
			end
			tmmu_pkg::CMD_GET_ACC: begin
				if (frame_bad_s1) begin
					st_c = tmmu_pkg::ST_FRAME;
				end else begin
					ao_c = bits_rd_data;
				end
			end
			tmmu_pkg::CMD_SET_TAG: begin
				if (set_tag_bad_s1) begin
					st_c = tmmu_pkg::ST_TAG;
				end else begin
					tag_set_c = 1'b1;
				end
			end
			tmmu_pkg::CMD_GET_TAG: begin
				to_c = cur_tag_q;
			end
			tmmu_pkg::CMD_ACCESS: begin
				// The frame flags are set through per-bit enables: bit 0 is the
				// reference flag and bit 1 the dirty flag.
				bits_wr_c.addr = ent_frame_s1;
				bits_wr_c.data = '1;
				if (page_bad_s1) begin
					st_c = tmmu_pkg::ST_PAGE;
				end else if (tmmu_pkg::tag_bad(cur_tag_q) || !ent_valid_s1) begin
					st_c = tmmu_pkg::ST_FAULT;
				end else if (ent_prot_s1 == tmmu_pkg::PROT_NOACC) begin
					st_c = tmmu_pkg::ST_VIOL;
				end else begin
					bits_wr_c.mask[0] = 1'b1;
					if (wr_s1) begin
						if (ent_prot_s1 == tmmu_pkg::PROT_RW) begin
							bits_wr_c.mask[1] = 1'b1;
						end else begin
							st_c = tmmu_pkg::ST_VIOL;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Memory writes: the clearing sweep owns both ports until it ends, after
	// that a command writes back only in the cycle it retires.
	always_comb begin
		if (clr.busy) begin
			map_wr.en      = 1'b1;
			map_wr.addr    = clr.addr;
			map_wr.data    = '0;
			bits_wr.mask   = '1;
			bits_wr.addr   = clr.addr[tmmu_pkg::FRAME_W-1:0];
			bits_wr.data   = '0;
		end else begin
			map_wr.en      = map_wr_c.en & done;
			map_wr.addr    = map_wr_c.addr;
			map_wr.data    = map_wr_c.data;
			bits_wr.mask   = bits_wr_c.mask & {tmmu_pkg::BITS_W{done}};
			bits_wr.addr   = bits_wr_c.addr;
			bits_wr.data   = bits_wr_c.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			cur_tag_q <= '0;
		end else if (done) begin
			if (cnt_inc_c) begin
				count_q <= count_q + 1'b1;
			end else if (cnt_dec_c) begin
				count_q <= count_q - 1'b1;
			end
			if (tag_set_c) begin
				cur_tag_q <= tag_s1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q    <= st_c;
			frame_out_q <= fo_c;
			prot_out_q  <= po_c;
			bits_out_q  <= ao_c;
			tag_out_q   <= to_c;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign frame_out       = frame_out_q;
	assign protection_out  = prot_out_q;
	assign access_bits_out = bits_out_q;
	assign tag_out         = tag_out_q;

endmodule

@@ hdl/tmmu_map_ram.sv @@
module tmmu_map_ram (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [tmmu_pkg::MAP_AW-1:0]   rd_addr,
	output logic [tmmu_pkg::ENTRY_W-1:0]  rd_data,
	input  tmmu_pkg::map_wr_t             wr
);

	logic [tmmu_pkg::ENTRY_W-1:0] mem_q [tmmu_pkg::MAP_DEPTH];
	logic [tmmu_pkg::ENTRY_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/tmmu_bits_ram.sv @@
module tmmu_bits_ram (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [tmmu_pkg::FRAME_W-1:0]  rd_addr,
	output logic [tmmu_pkg::BITS_W-1:0]   rd_data,
	input  tmmu_pkg::bits_wr_t            wr
);

	logic [tmmu_pkg::BITS_W-1:0] mem_q [tmmu_pkg::MAX_FRAMES];
	logic [tmmu_pkg::BITS_W-1:0] rd_data_q;

	// Each bit has its own enable, so an access sets a flag without a read.
	always_ff @(posedge clk) begin
		for (int b = 0; b < tmmu_pkg::BITS_W; b++) begin
			if (wr.mask[b]) begin
				mem_q[wr.addr][b] <= wr.data[b];
			end
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/tmmu_clear.sv @@
module tmmu_clear (
	input  logic          clk,
	input  logic          arst_n,
	output tmmu_pkg::clr_t clr
);

	logic                        busy_q;
	logic [tmmu_pkg::MAP_AW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == tmmu_pkg::MAP_AW'(tmmu_pkg::MAP_DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign clr.busy = busy_q;
	assign clr.addr = cnt_q;

endmodule

@@ test/tagged_mmu_map_table_checker.sv @@
`timescale 1ns / 1ps

module tagged_mmu_map_table_checker
	import tmmu_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [2:0]                   command,
	input  logic signed [TAG_W-1:0]      tag_in,
	input  logic [PAGE_W-1:0]            page_in,
	input  logic [FRAME_W-1:0]           frame_in,
	input  logic [PROT_W-1:0]            protection_in,
	input  logic [BITS_W-1:0]            access_bits_in,
	input  logic                         is_write,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [STATUS_W-1:0]          status,
	input  logic [FRAME_W-1:0]           frame_out,
	input  logic [PROT_W-1:0]            protection_out,
	input  logic [BITS_W-1:0]            access_bits_out,
	input  logic signed [TAG_W-1:0]      tag_out,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	output int                           fail_count,
	output int                           pending,
	output int                           results_checked
);

	typedef struct packed {
		logic               valid;
		logic [FRAME_W-1:0] frame;
		logic [PROT_W-1:0]  prot;
	} page_entry_t;

	typedef struct {
		cmd_t                    cmd;
		logic signed [TAG_W-1:0] tag;
		logic [PAGE_W-1:0]       page;
		logic [FRAME_W-1:0]      frame;
		logic [PROT_W-1:0]       prot;
		logic [BITS_W-1:0]       bits;
		logic                    wr;
	} mmu_cmd_t;

	typedef struct {
		status_t                 status;
		logic [FRAME_W-1:0]      frame;
		logic [PROT_W-1:0]       prot;
		logic [BITS_W-1:0]       bits;
		logic signed [TAG_W-1:0] tag;
	} mmu_result_t;

	page_entry_t       page_map [NUM_TAGS][MAX_PAGES];
	logic [BITS_W-1:0] frame_flags [MAX_FRAMES];
	int                live_maps;
	int                active_tag;
	int                page_limit;
	int                frame_limit;
	int                map_limit;
	mmu_result_t       expected_q [$];

	function automatic logic page_out_of_range(input logic [PAGE_W-1:0] p);
		return int'(p) >= page_limit || int'(p) >= MAX_PAGES;
	endfunction

	function automatic logic frame_out_of_range(input logic [FRAME_W-1:0] f);
		return int'(f) >= frame_limit || int'(f) >= MAX_FRAMES;
	endfunction

	function automatic logic tag_unusable(input int t);
		return t < 0 || t >= NUM_TAGS;
	endfunction

	// Applies one command to the local copy of the table and returns its result.
	function automatic mmu_result_t predict_result(input mmu_cmd_t c);
		mmu_result_t r;
		page_entry_t e;
		int          t;
		r.status = ST_OK;
		r.frame  = '0;
		r.prot   = '0;
		r.bits   = '0;
		r.tag    = '0;
		t = $signed(c.tag);
		case (c.cmd)
			CMD_MAP: begin
				if (page_out_of_range(c.page)) r.status = ST_PAGE;
				else if (frame_out_of_range(c.frame)) r.status = ST_FRAME;
				else if (live_maps >= map_limit) r.status = ST_MAPS;
				else if (c.prot == PROT_BAD) r.status = ST_PROT;
				else if (tag_unusable(t)) r.status = ST_TAG;
				else if (page_map[t][c.page].valid) r.status = ST_REMAP;
				else begin
					page_map[t][c.page] = '{1'b1, c.frame, c.prot};
					live_maps++;
				end
			end
			CMD_UNMAP, CMD_GET_MAP: begin
				if (page_out_of_range(c.page)) r.status = ST_PAGE;
				else if (tag_unusable(t)) r.status = ST_TAG;
				else begin
					e = page_map[t][c.page];
					if (!e.valid) r.status = ST_NOMAP;
					else if (c.cmd == CMD_UNMAP) begin
						page_map[t][c.page] = '0;
						if (live_maps > 0) live_maps--;
					end else begin
						r.frame = e.frame;
						r.prot  = e.prot;
					end
				end
			end
			CMD_SET_ACC: begin
				if (frame_out_of_range(c.frame)) r.status = ST_FRAME;
				else frame_flags[c.frame] = c.bits;
			end
			CMD_GET_ACC: begin
				if (frame_out_of_range(c.frame)) r.status = ST_FRAME;
				else r.bits = frame_flags[c.frame];
			end
			CMD_SET_TAG: begin
				if (t < -1 || t >= NUM_TAGS) r.status = ST_TAG;
				else active_tag = t;
			end
			CMD_GET_TAG: begin
				r.tag = TAG_W'(active_tag);
			end
			default: begin
				if (page_out_of_range(c.page)) r.status = ST_PAGE;
				else if (tag_unusable(active_tag)) r.status = ST_FAULT;
				else begin
					e = page_map[active_tag][c.page];
					if (!e.valid) r.status = ST_FAULT;
					else if (e.prot == PROT_NOACC) r.status = ST_VIOL;
					else begin
						// Any permitted access marks the frame referenced, even a
						// write that is then refused on a read-only page.
						frame_flags[e.frame][0] = 1'b1;
						if (c.wr) begin
							if (e.prot == PROT_RW) frame_flags[e.frame][1] = 1'b1;
							else r.status = ST_VIOL;
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mmu_cmd_t    c;
		mmu_result_t want;
		if (!arst_n) begin
			for (int t = 0; t < NUM_TAGS; t++)
				for (int p = 0; p < MAX_PAGES; p++)
					page_map[t][p] = '0;
			for (int f = 0; f < MAX_FRAMES; f++)
				frame_flags[f] = '0;
			live_maps       = 0;
			active_tag      = 0;
			page_limit      = int'(PAGES_RESET);
			frame_limit     = int'(FRAMES_RESET);
			map_limit       = int'(LIMIT_RESET);
			fail_count      = 0;
			results_checked = 0;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PAGES:  page_limit  = int'(cfg_data[PAGES_W-1:0]);
					CFG_FRAMES: frame_limit = int'(cfg_data[FRAMES_W-1:0]);
					CFG_LIMIT:  map_limit   = int'(cfg_data[LIMIT_W-1:0]);
					default: ;
				endcase
			end
			// Results are checked before new commands are predicted, since a result
			// never belongs to a command taken at the same edge.
			if (out_valid && !out_stall) begin
				results_checked++;
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result with no command outstanding: status %0d",
							$time, status);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (status != want.status || frame_out != want.frame ||
						protection_out != want.prot || access_bits_out != want.bits ||
						tag_out != want.tag) begin
						if (fail_count < 10)
							$display({"%0t: mismatch: expected status %0d frame %0d prot %0d ",
								"bits %0d tag %0d, got status %0d frame %0d prot %0d ",
								"bits %0d tag %0d"}, $time, want.status, want.frame,
								want.prot, want.bits, want.tag, status, frame_out,
								protection_out, access_bits_out, tag_out);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				c.cmd   = cmd_t'(command);
				c.tag   = tag_in;
				c.page  = page_in;
				c.frame = frame_in;
				c.prot  = protection_in;
				c.bits  = access_bits_in;
				c.wr    = is_write;
				expected_q.push_back(predict_result(c));
			end
			pending <= expected_q.size();
		end
	end

endmodule

@@ test/tagged_mmu_map_table_tb.sv @@
`timescale 1ns / 1ps

module tagged_mmu_map_table_tb;
	import tmmu_pkg::*;

	// Cycles with no transaction on any channel before the run is declared hung.
	// The clearing sweep after reset and the long receiver hold below both
	// count towards it.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 10;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 124;
	localparam int PAGE_WINDOW    = 8;
	localparam int FRAME_WINDOW   = 16;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [2:0]              command = CMD_GET_TAG;
	logic signed [TAG_W-1:0] tag_in = '0;
	logic [PAGE_W-1:0]       page_in = '0;
	logic [FRAME_W-1:0]      frame_in = '0;
	logic [PROT_W-1:0]       protection_in = PROT_NOACC;
	logic [BITS_W-1:0]       access_bits_in = '0;
	logic                    is_write = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [STATUS_W-1:0]     status;
	logic [FRAME_W-1:0]      frame_out;
	logic [PROT_W-1:0]       protection_out;
	logic [BITS_W-1:0]       access_bits_out;
	logic signed [TAG_W-1:0] tag_out;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = CFG_NONE;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	int fail_count;
	int pending;
	int results_checked;

	// Shared between the command side and the result side: whether random gaps
	// are inserted at all in this stretch, and how many long holds were asked.
	logic gaps_on = 1'b1;
	int   hold_requests = 0;
	int   idle_cycles = 0;
	int   commands_sent = 0;
	int   settings_used = 0;

	always #5 clk = ~clk;

	tagged_mmu_map_table u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.tag_in          (tag_in),
		.page_in         (page_in),
		.frame_in        (frame_in),
		.protection_in   (protection_in),
		.access_bits_in  (access_bits_in),
		.is_write        (is_write),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.frame_out       (frame_out),
		.protection_out  (protection_out),
		.access_bits_out (access_bits_out),
		.tag_out         (tag_out),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	tagged_mmu_map_table_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.tag_in          (tag_in),
		.page_in         (page_in),
		.frame_in        (frame_in),
		.protection_in   (protection_in),
		.access_bits_in  (access_bits_in),
		.is_write        (is_write),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.frame_out       (frame_out),
		.protection_out  (protection_out),
		.access_bits_out (access_bits_out),
		.tag_out         (tag_out),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	// Length of an idle stretch: usually none or a few cycles, now and then a
	// long one. Both the command side and the result side draw from this.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offers one command transaction and returns at the edge that takes it.
	// The valid line is only lowered when a gap actually follows, so back-to-back
	// commands keep it high.
	task automatic send_cmd(input cmd_t c, input logic [TAG_W-1:0] t,
		input logic [PAGE_W-1:0] p, input logic [FRAME_W-1:0] f,
		input logic [PROT_W-1:0] pr, input logic [BITS_W-1:0] b, input logic w);
		int gap;
		gap = gaps_on ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		command        <= c;
		tag_in         <= t;
		page_in        <= p;
		frame_in       <= f;
		protection_in  <= pr;
		access_bits_in <= b;
		is_write       <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		commands_sent++;
	endtask

	// Stops offering commands and waits until every result has come back. The
	// first edge lets the checker count a command taken at the current edge.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Writes all three size registers; only called once the block is idle.
	task automatic set_sizes(input int pages, input int frames, input int limit);
		write_reg(CFG_PAGES, CFG_DATA_W'(pages));
		write_reg(CFG_FRAMES, CFG_DATA_W'(frames));
		write_reg(CFG_LIMIT, CFG_DATA_W'(limit));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic cmd_t pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return CMD_MAP;
		if (r < 37) return CMD_UNMAP;
		if (r < 49) return CMD_GET_MAP;
		if (r < 57) return CMD_SET_ACC;
		if (r < 67) return CMD_GET_ACC;
		if (r < 73) return CMD_SET_TAG;
		if (r < 77) return CMD_GET_TAG;
		return CMD_ACCESS;
	endfunction

	// Mostly usable tags so that mappings build up, with the no-context tag and
	// the full five-bit range mixed in.
	function automatic logic [TAG_W-1:0] pick_tag();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return TAG_W'($urandom_range(0, NUM_TAGS - 1));
		if (r < 90) return TAG_NONE;
		return TAG_W'($urandom_range(0, 31));
	endfunction

	function automatic logic [PROT_W-1:0] pick_prot();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return PROT_BAD;
		if (r == 1) return PROT_NOACC;
		if (r < 6) return PROT_RO;
		return PROT_RW;
	endfunction

	// A register value for a random phase: one of the extremes or a small size.
	function automatic int pick_size(input int top_value, input int mid_max);
		int r;
		r = $urandom_range(0, 2);
		if (r == 0) return 1;
		if (r == 1) return top_value;
		return $urandom_range(2, mid_max);
	endfunction

	// Pages and frames come mostly from a small window so that maps, lookups and
	// accesses keep hitting the same entries; the rest cover the whole field.
	task automatic send_random();
		logic [PAGE_W-1:0]  p;
		logic [FRAME_W-1:0] f;
		p = ($urandom_range(0, 4) != 0) ? PAGE_W'($urandom_range(0, PAGE_WINDOW - 1))
			: PAGE_W'($urandom_range(0, 255));
		f = ($urandom_range(0, 9) < 7) ? FRAME_W'($urandom_range(0, FRAME_WINDOW - 1))
			: FRAME_W'($urandom_range(0, 255));
		send_cmd(pick_cmd(), pick_tag(), p, f, pick_prot(), BITS_W'($urandom_range(0, 3)),
			1'($urandom_range(0, 1)));
	endtask

	// Result side. Random stalls of mixed length, none at all while gaps are
	// off, and a long hold counted here whenever the command side asks for one.
	initial begin : result_side
		int n;
		int served;
		served = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != served) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				served++;
			end else if (gaps_on) begin
				n = idle_len();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Any transaction on any channel counts as progress.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset sizes. The first command waits out the
		// clearing sweep, during which the block stalls its input.
		send_cmd(CMD_GET_TAG, 5'd0, 8'd0, 8'd0, PROT_NOACC, 2'd0, 1'b0);
		send_cmd(CMD_ACCESS, 5'd0, 8'd0, 8'd0, PROT_NOACC, 2'd0, 1'b0);     // unmapped page
		send_cmd(CMD_MAP, 5'd0, 8'd0, 8'd0, PROT_RW, 2'd0, 1'b0);
		send_cmd(CMD_MAP, 5'd0, 8'd0, 8'd9, PROT_RO, 2'd0, 1'b0);          // remap
		send_cmd(CMD_MAP, 5'd0, 8'd255, 8'd255, PROT_RO, 2'd0, 1'b0);
		send_cmd(CMD_MAP, 5'd3, 8'd1, 8'd2, PROT_NOACC, 2'd0, 1'b0);
		send_cmd(CMD_MAP, 5'd1, 8'd7, 8'd7, PROT_BAD, 2'd0, 1'b0);         // bad protection rejected
		send_cmd(CMD_MAP, 5'd4, 8'd7, 8'd7, PROT_RW, 2'd0, 1'b0);          // tag past the last
		send_cmd(CMD_MAP, TAG_NONE, 8'd7, 8'd7, PROT_RW, 2'd0, 1'b0);
		send_cmd(CMD_GET_MAP, 5'd0, 8'd0, 8'd0, PROT_NOACC, 2'd0, 1'b0);
		send_cmd(CMD_GET_MAP, 5'd2, 8'd5, 8'd0, PROT_NOACC, 2'd0, 1'b0);    // no mapping
		send_cmd(CMD_GET_MAP, 5'b10000, 8'd0, 8'd0, PROT_NOACC, 2'd0, 1'b0); // most negative tag
		send_cmd(CMD_ACCESS, 5'd0, 8'd0, 8'd0, PROT_NOACC, 2'd0, 1'b0);
		send_cmd(CMD_ACCESS, 5'd0, 8'd0, 8'd0, PROT_NOACC, 2'd0, 1'b1);     // sets dirty
		send_cmd(CMD_GET_ACC, 5'd0, 8'd0, 8'd0, PROT_NOACC, 2'd0, 1'b0);
		send_cmd(CMD_ACCESS, 5'd0, 8'd255, 8'd0, PROT_NOACC, 2'd0, 1'b1);   // write to read-only
		send_cmd(CMD_GET_ACC, 5'd0, 8'd0, 8'd255, PROT_NOACC, 2'd0, 1'b0);
		send_cmd(CMD_SET_TAG, 5'd3, 8'd0, 8'd0, PROT_NOACC, 2'd0, 1'b0);
		send_cmd(CMD_ACCESS, 5'd0, 8'd1, 8'd0, PROT_NOACC, 2'd0, 1'b0);     // no permission
		send_cmd(CMD_SET_TAG, TAG_NONE, 8'd0, 8'd0, PROT_NOACC, 2'd0, 1'b0);
		send_cmd(CMD_ACCESS, 5'd0, 8'd0, 8'd0, PROT_NOACC, 2'd0, 1'b0);     // no context
		send_cmd(CMD_GET_TAG, 5'd0, 8'd0, 8'd0, PROT_NOACC, 2'd0, 1'b0);
		send_cmd(CMD_SET_TAG, 5'd15, 8'd0, 8'd0, PROT_NOACC, 2'd0, 1'b0);
		send_cmd(CMD_SET_TAG, 5'b11110, 8'd0, 8'd0, PROT_NOACC, 2'd0, 1'b0);
		send_cmd(CMD_SET_ACC, 5'd0, 8'd0, 8'd255, PROT_NOACC, 2'd2, 1'b0);
		send_cmd(CMD_UNMAP, 5'd0, 8'd0, 8'd0, PROT_NOACC, 2'd0, 1'b0);
		send_cmd(CMD_UNMAP, 5'd0, 8'd0, 8'd0, PROT_NOACC, 2'd0, 1'b0);      // already gone
		send_cmd(CMD_SET_TAG, 5'd0, 8'd0, 8'd0, PROT_NOACC, 2'd0, 1'b0);

		// Shrink everything to one: the stored mappings now exceed the limit,
		// and page and frame one fall out of range. The unused index is written
		// too, and must change nothing.
		drain();
		write_reg(CFG_NONE, CFG_DATA_W'($urandom_range(0, 2047)));
		set_sizes(1, 1, 1);
		send_cmd(CMD_MAP, 5'd1, 8'd1, 8'd0, PROT_RW, 2'd0, 1'b0);
		send_cmd(CMD_MAP, 5'd1, 8'd0, 8'd1, PROT_RW, 2'd0, 1'b0);
		send_cmd(CMD_MAP, 5'd1, 8'd0, 8'd0, PROT_RW, 2'd0, 1'b0);          // over the limit
		send_cmd(CMD_ACCESS, 5'd0, 8'd255, 8'd0, PROT_NOACC, 2'd0, 1'b0);   // hidden page
		send_cmd(CMD_GET_ACC, 5'd0, 8'd0, 8'd255, PROT_NOACC, 2'd0, 1'b0);

		// Random phases, each under its own sizes and with or without gaps.
		// Every phase boundary is a point where the command side waits for all
		// results to come back before touching the registers.
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: set_sizes(256, 256, 1024);
				1: set_sizes(1, 1, 1);
				2: set_sizes(8, 16, 1024);
				3: set_sizes(256, 256, $urandom_range(2, 12));
				4: set_sizes(4, 4, 1024);
				default: set_sizes(pick_size(256, 32), pick_size(256, 32), pick_size(1024, 64));
			endcase
			gaps_on <= ($urandom_range(0, 3) != 0);
			if (ph == 3) begin
				// Long hold on the result side while commands keep coming, so the
				// block fills up and stalls its input.
				hold_requests <= hold_requests + 1;
			end
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d commands over %0d register settings, %0d results checked.",
			commands_sent, settings_used, results_checked);
		$display("Sizes ranged from one page, frame and mapping up to the full table.");
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
